@@ rtl/lts_pkg.sv @@
// ----------------------------------------------------------------------------
// Lua token scanner package
// Scan modes, token kinds and default sizes shared by the scanner files.
// ----------------------------------------------------------------------------
package lts_pkg;

    localparam int MAX_LEVEL_DEF = 15;
    localparam int POS_BITS_DEF  = 20;
    localparam int LINE_BITS_DEF = 16;
    localparam int WORD_DEPTH    = 6;
    localparam int MAX_RESULTS   = 3;

    typedef enum logic [4:0] {
        M_IDLE, M_DASH, M_DASH2, M_CSHORT, M_CSEP, M_LOPEN, M_LBODY_C, M_LBODY_S,
        M_LCLOSE_C, M_LCLOSE_S, M_PAIR, M_STR, M_ESC, M_HEX, M_DEC, M_ZAP,
        M_DOT1, M_DOT2, M_NUM, M_NUM_E, M_NUM_S, M_NAME
    } mode_t;

    typedef enum logic [3:0] {
        KIND_CHAR = 4'd0, KIND_ERROR = 4'd1, KIND_EOF = 4'd2, KIND_STRING = 4'd3,
        KIND_NUMBER = 4'd4, KIND_NAME = 4'd5, KIND_RETURN = 4'd6, KIND_NIL = 4'd7,
        KIND_EQ = 4'd8, KIND_LE = 4'd9, KIND_GE = 4'd10, KIND_NE = 4'd11,
        KIND_DCOLON = 4'd12, KIND_DOTS3 = 4'd13, KIND_DOTS2 = 4'd14
    } kind_t;

endpackage

@@ rtl/lts_byte_if.sv @@
// ----------------------------------------------------------------------------
// Source byte channel
// Carries one source byte per request with an end-of-text flag.
// ----------------------------------------------------------------------------
interface lts_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] source_byte;
    logic       last_byte;

    modport source (output valid, source_byte, last_byte, input ready);
    modport sink   (input valid, source_byte, last_byte, output ready);
endinterface

@@ rtl/lts_token_if.sv @@
// ----------------------------------------------------------------------------
// Token channel
// Carries one scanned token per request with its positions and line.
// ----------------------------------------------------------------------------
interface lts_token_if
    import lts_pkg::*;
#(
    parameter int POS_BITS  = POS_BITS_DEF,
    parameter int LINE_BITS = LINE_BITS_DEF
);
    logic                 valid;
    logic                 ready;
    logic [3:0]           token_kind;
    logic [7:0]           token_char;
    logic [POS_BITS-1:0]  token_start;
    logic [POS_BITS-1:0]  token_end;
    logic [LINE_BITS-1:0] token_line;
    logic                 last_token;

    modport source (output valid, token_kind, token_char, token_start, token_end,
                    token_line, last_token, input ready);
    modport sink   (input valid, token_kind, token_char, token_start, token_end,
                    token_line, last_token, output ready);
endinterface

@@ rtl/lua_token_scanner_top.sv @@
// ----------------------------------------------------------------------------
// Lua token scanner
// A source byte is registered in the input register when taken, scanned once
// the result register is free; its tokens are then registered and offered.
// Throughput: one byte per cycle while tokens are taken as offered; a byte that
// yields several tokens holds the result register until all are taken, which
// sets the rate on token-dense text.
// Reset (rst_n, asynchronous, active low) returns the scanner to the start
// of a text at offset 0, line 0, with no request pending on either side.
// ----------------------------------------------------------------------------
module lua_token_scanner_top
    import lts_pkg::*;
#(
    parameter int MAX_LEVEL = MAX_LEVEL_DEF,
    parameter int POS_BITS  = POS_BITS_DEF,
    parameter int LINE_BITS = LINE_BITS_DEF
)(
    input  logic        clk,
    input  logic        rst_n,
    lts_byte_if.sink    src,
    lts_token_if.source tok
);

    // Level counters must hold one more than the largest level, since a
    // closing run may count one '=' past it before it is known to mismatch.
    localparam int LVL_BITS = $clog2(MAX_LEVEL + 2);

    typedef logic [POS_BITS-1:0]  pos_t;
    typedef logic [LINE_BITS-1:0] line_t;
    typedef logic [LVL_BITS-1:0]  lvl_t;

    // All scanner state except the byte offset, which moves once per byte.
    typedef struct packed {
        mode_t      mode;
        pos_t       token_begin;
        line_t      line_count;
        lvl_t       open_level;
        lvl_t       close_level;
        logic [7:0] quote_kind;
        logic [9:0] escape_value;
        logic [1:0] escape_digits;
        logic [WORD_DEPTH-1:0][7:0] word_store;
        logic [2:0] word_length;
    } scan_t;

    typedef struct packed {
        kind_t      kind;
        logic [7:0] ch;
        pos_t       start;
        pos_t       stop;
        line_t      line;
    } token_t;

    // Outcome of one look at the current byte in one scan mode.
    typedef struct packed {
        scan_t  s;
        logic   emit;
        logic   again;
        token_t tk;
    } pass_t;

    // ------------------------------------------------------------------
    // Character classes (ASCII only).
    // ------------------------------------------------------------------
    function automatic logic is_digit(logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic logic is_alpha(logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
    endfunction

    function automatic logic is_hex(logic [7:0] c);
        return is_digit(c) || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
    endfunction

    function automatic logic is_nl(logic [7:0] c);
        return c == 8'h0A || c == 8'h0D;
    endfunction

    function automatic logic is_space(logic [7:0] c);
        return c == 8'h20 || c == 8'h09 || c == 8'h0B || c == 8'h0C;
    endfunction

    function automatic line_t line_inc(line_t l);
        return (l == '1) ? l : l + 1'b1;
    endfunction

    function automatic kind_t word_kind(scan_t s);
        if (s.word_length == 3'd6 && s.word_store[0] == "r" && s.word_store[1] == "e" &&
            s.word_store[2] == "t" && s.word_store[3] == "u" && s.word_store[4] == "r" &&
            s.word_store[5] == "n")
            return KIND_RETURN;
        if (s.word_length == 3'd3 && s.word_store[0] == "n" && s.word_store[1] == "i" &&
            s.word_store[2] == "l")
            return KIND_NIL;
        return KIND_NAME;
    endfunction

    function automatic scan_t reset_scan();
        scan_t r;
        r = '0;
        r.mode = M_IDLE;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // One pass of the scanner over the byte. A pass that hands the byte on
    // (again) is followed by another pass in the new mode; at most three
    // passes happen, since hand-ons go to idle, short comment, string or
    // long-bracket body; only comment and string hand on, then to idle.
    // ------------------------------------------------------------------
    function automatic pass_t run_pass(scan_t s, logic [7:0] c, pos_t here, pos_t after);
        pass_t      p;
        kind_t      k;
        logic       hit;
        logic [9:0] dec;
        p       = '0;
        p.s     = s;
        p.tk.kind = KIND_CHAR;
        p.tk.stop = here;
        k       = KIND_CHAR;
        hit     = 1'b0;
        dec     = (s.escape_value << 3) + (s.escape_value << 1) + 10'(c - "0");
        unique case (s.mode)
            M_IDLE:
            begin
                p.s.token_begin = here;
                if (is_nl(c))
                    p.s.line_count = line_inc(s.line_count);
                else if (is_space(c))
                    p.s.mode = M_IDLE;
                else if (c == "-")
                    p.s.mode = M_DASH;
                else if (c == "[")
                begin
                    p.s.open_level = '0;
                    p.s.mode       = M_LOPEN;
                end
                else if (c == "=" || c == "<" || c == ">" || c == "~" || c == ":")
                begin
                    p.s.quote_kind = c;
                    p.s.mode       = M_PAIR;
                end
                else if (c == 8'h22 || c == 8'h27)
                begin
                    p.s.quote_kind = c;
                    p.s.mode       = M_STR;
                end
                else if (c == ".")
                    p.s.mode = M_DOT1;
                else if (is_digit(c))
                    p.s.mode = M_NUM;
                else if (is_alpha(c))
                begin
                    p.s.word_store[0] = c;
                    p.s.word_length   = 3'd1;
                    p.s.mode          = M_NAME;
                end
                else
                begin
                    p.emit = 1'b1; p.tk.ch = c; p.tk.stop = after;
                end
            end
            M_DASH:
            begin
                if (c == "-")
                    p.s.mode = M_DASH2;
                else
                begin
                    p.emit = 1'b1; p.tk.ch = "-";
                    p.s.mode = M_IDLE; p.again = 1'b1;
                end
            end
            M_DASH2:
            begin
                if (c == "[")
                begin
                    p.s.open_level = '0;
                    p.s.mode       = M_CSEP;
                end
                else
                begin
                    p.s.mode = M_CSHORT; p.again = 1'b1;
                end
            end
            M_CSHORT:
            begin
                if (is_nl(c))
                begin
                    p.s.mode = M_IDLE; p.again = 1'b1;
                end
            end
            M_CSEP:
            begin
                if (c == "=")
                begin
                    if (s.open_level < LVL_BITS'(MAX_LEVEL))
                        p.s.open_level = s.open_level + 1'b1;
                    else
                        p.s.mode = M_CSHORT;
                end
                else if (c == "[")
                    p.s.mode = M_LBODY_C;
                else
                begin
                    p.s.mode = M_CSHORT; p.again = 1'b1;
                end
            end
            M_LOPEN:
            begin
                if (c == "=")
                begin
                    if (s.open_level < LVL_BITS'(MAX_LEVEL))
                        p.s.open_level = s.open_level + 1'b1;
                    else
                    begin
                        p.emit = 1'b1; p.tk.kind = KIND_ERROR; p.tk.stop = after;
                        p.s.mode = M_IDLE;
                    end
                end
                else if (c == "[")
                    p.s.mode = M_LBODY_S;
                else
                begin
                    p.emit = 1'b1;
                    if (s.open_level == '0)
                        p.tk.ch = "[";
                    else
                        p.tk.kind = KIND_ERROR;
                    p.s.mode = M_IDLE; p.again = 1'b1;
                end
            end
            M_LBODY_C, M_LBODY_S:
            begin
                if (c == "]")
                begin
                    p.s.close_level = '0;
                    p.s.mode = (s.mode == M_LBODY_S) ? M_LCLOSE_S : M_LCLOSE_C;
                end
                else if (is_nl(c))
                    p.s.line_count = line_inc(s.line_count);
            end
            M_LCLOSE_C, M_LCLOSE_S:
            begin
                if (c == "=")
                begin
                    if (s.close_level <= LVL_BITS'(MAX_LEVEL))
                        p.s.close_level = s.close_level + 1'b1;
                end
                else if (c == "]")
                begin
                    if (s.close_level == s.open_level)
                    begin
                        if (s.mode == M_LCLOSE_S)
                        begin
                            p.emit = 1'b1; p.tk.kind = KIND_STRING; p.tk.stop = after;
                        end
                        p.s.mode = M_IDLE;
                    end
                    else
                        p.s.close_level = '0;
                end
                else
                begin
                    p.s.mode  = (s.mode == M_LCLOSE_S) ? M_LBODY_S : M_LBODY_C;
                    p.again = 1'b1;
                end
            end
            M_PAIR:
            begin
                if (c == "=")
                begin
                    hit = 1'b1;
                    if (s.quote_kind == "=")
                        k = KIND_EQ;
                    else if (s.quote_kind == "<")
                        k = KIND_LE;
                    else if (s.quote_kind == ">")
                        k = KIND_GE;
                    else if (s.quote_kind == "~")
                        k = KIND_NE;
                    else
                        hit = 1'b0;
                end
                else if (c == ":" && s.quote_kind == ":")
                begin
                    hit = 1'b1; k = KIND_DCOLON;
                end
                p.emit   = 1'b1;
                p.s.mode = M_IDLE;
                if (hit)
                begin
                    p.tk.kind = k; p.tk.stop = after;
                end
                else
                begin
                    p.tk.ch = s.quote_kind; p.again = 1'b1;
                end
            end
            M_STR:
            begin
                if (c == s.quote_kind)
                begin
                    p.emit = 1'b1; p.tk.kind = KIND_STRING; p.tk.stop = after;
                    p.s.mode = M_IDLE;
                end
                else if (is_nl(c))
                begin
                    p.emit = 1'b1; p.tk.kind = KIND_ERROR;
                    p.s.mode = M_IDLE; p.again = 1'b1;
                end
                else if (c == 8'h5C)
                    p.s.mode = M_ESC;
            end
            M_ESC:
            begin
                if (c == "x")
                begin
                    p.s.escape_digits = '0; p.s.mode = M_HEX;
                end
                else if (is_nl(c))
                begin
                    p.s.line_count = line_inc(s.line_count); p.s.mode = M_STR;
                end
                else if (c == "z")
                    p.s.mode = M_ZAP;
                else if (is_digit(c))
                begin
                    p.s.escape_value  = 10'(c - "0");
                    p.s.escape_digits = 2'd1;
                    p.s.mode          = M_DEC;
                end
                else if (c == 8'h00)
                begin
                    p.emit = 1'b1; p.tk.kind = KIND_ERROR;
                    p.s.mode = M_IDLE; p.again = 1'b1;
                end
                else
                    p.s.mode = M_STR;
            end
            M_HEX:
            begin
                if (is_hex(c))
                begin
                    p.s.escape_digits = s.escape_digits + 1'b1;
                    if (s.escape_digits != 2'd0)
                        p.s.mode = M_STR;
                end
                else
                begin
                    p.emit = 1'b1; p.tk.kind = KIND_ERROR;
                    p.s.mode = M_IDLE; p.again = 1'b1;
                end
            end
            M_DEC:
            begin
                if (is_digit(c))
                begin
                    p.s.escape_value  = dec;
                    p.s.escape_digits = s.escape_digits + 1'b1;
                    if (s.escape_digits == 2'd2)
                    begin
                        if (dec > 10'd255)
                        begin
                            p.emit = 1'b1; p.tk.kind = KIND_ERROR; p.tk.stop = after;
                            p.s.mode = M_IDLE;
                        end
                        else
                            p.s.mode = M_STR;
                    end
                end
                else
                begin
                    p.s.mode = M_STR; p.again = 1'b1;
                end
            end
            M_ZAP:
            begin
                if (is_nl(c))
                    p.s.line_count = line_inc(s.line_count);
                else if (!is_space(c))
                begin
                    p.s.mode = M_STR; p.again = 1'b1;
                end
            end
            M_DOT1:
            begin
                if (c == ".")
                    p.s.mode = M_DOT2;
                else if (is_digit(c))
                    p.s.mode = M_NUM;
                else
                begin
                    p.emit = 1'b1; p.tk.ch = ".";
                    p.s.mode = M_IDLE; p.again = 1'b1;
                end
            end
            M_DOT2:
            begin
                p.emit   = 1'b1;
                p.s.mode = M_IDLE;
                if (c == ".")
                begin
                    p.tk.kind = KIND_DOTS3; p.tk.stop = after;
                end
                else
                begin
                    p.tk.kind = KIND_DOTS2; p.again = 1'b1;
                end
            end
            M_NUM, M_NUM_E, M_NUM_S:
            begin
                if (s.mode == M_NUM && (c == "e" || c == "E"))
                    p.s.mode = M_NUM_E;
                else if (s.mode == M_NUM_E && (c == "+" || c == "-"))
                    p.s.mode = M_NUM_S;
                else if (is_digit(c) || c == ".")
                    p.s.mode = M_NUM;
                else
                begin
                    p.emit = 1'b1; p.tk.kind = KIND_NUMBER;
                    p.s.mode = M_IDLE; p.again = 1'b1;
                end
            end
            M_NAME:
            begin
                if (is_alpha(c) || is_digit(c))
                begin
                    for (int i = 0; i < WORD_DEPTH; i++)
                    begin
                        if (s.word_length == 3'(i))
                            p.s.word_store[i] = c;
                    end
                    if (s.word_length != 3'd7)
                        p.s.word_length = s.word_length + 1'b1;
                end
                else
                begin
                    p.emit = 1'b1; p.tk.kind = word_kind(s);
                    p.s.mode = M_IDLE; p.again = 1'b1;
                end
            end
            default:
            begin
                p.s.mode = M_IDLE; p.again = 1'b1;
            end
        endcase
        p.tk.start = p.s.token_begin;
        p.tk.line  = p.s.line_count;
        return p;
    endfunction

    // ------------------------------------------------------------------
    // Input register.
    // ------------------------------------------------------------------
    logic       in_vld_reg;
    logic [7:0] in_byte_reg;
    logic       in_last_reg;

    // Scanner state.
    scan_t scan_reg, scan_next;
    pos_t  pos_reg, pos_next;

    // Result register: the tokens of one byte, handed out one per request.
    token_t     slot_reg [MAX_RESULTS];
    token_t     slot_next [MAX_RESULTS];
    logic [1:0] cnt_reg, cnt_next;
    logic [1:0] idx_reg, idx_next;

    logic       drain_done;
    logic       bundle_free;
    logic       process;
    logic [1:0] res_n;
    pos_t       here;
    pos_t       after;
    pass_t      p1, p2, p3;
    scan_t      fs;
    token_t     pend;
    logic       pend_ok;

    assign drain_done  = (cnt_reg != 2'd0) && tok.ready && (idx_reg == cnt_reg - 2'd1);
    assign bundle_free = (cnt_reg == 2'd0) || drain_done;
    assign process     = in_vld_reg && bundle_free;
    assign src.ready   = !in_vld_reg || bundle_free;

    assign here  = pos_reg;
    assign after = (pos_reg == '1) ? pos_reg : pos_reg + 1'b1;

    // Scan the registered byte: up to three passes, then the end-of-text
    // flush when the byte closes the text.
    always_comb
    begin
        p1 = run_pass(scan_reg, in_byte_reg, here, after);
        p2 = p1.again ? run_pass(p1.s, in_byte_reg, here, after) : p1;
        p3 = (p1.again && p2.again) ? run_pass(p2.s, in_byte_reg, here, after) : p2;
        if (!p1.again)
            p2.emit = 1'b0;
        if (!(p1.again && p2.again))
            p3.emit = 1'b0;

        res_n = 2'd0;
        for (int i = 0; i < MAX_RESULTS; i++)
            slot_next[i] = '0;
        if (p1.emit)
        begin
            slot_next[0] = p1.tk; res_n = 2'd1;
        end
        if (p2.emit && res_n != 2'd3)
        begin
            slot_next[res_n] = p2.tk; res_n = res_n + 2'd1;
        end
        if (p3.emit && res_n != 2'd3)
        begin
            slot_next[res_n] = p3.tk; res_n = res_n + 2'd1;
        end

        fs        = p3.s;
        scan_next = fs;
        pos_next  = after;

        // A pending token is flushed as it stands; open strings become errors.
        pend       = '0;
        pend.kind  = KIND_CHAR;
        pend.start = fs.token_begin;
        pend.stop  = after;
        pend.line  = fs.line_count;
        pend_ok    = 1'b1;
        unique case (fs.mode)
            M_DASH:
                pend.ch = "-";
            M_LOPEN:
            begin
                if (fs.open_level == '0)
                    pend.ch = "[";
                else
                    pend.kind = KIND_ERROR;
            end
            M_LBODY_S, M_LCLOSE_S, M_STR, M_ESC, M_HEX, M_DEC, M_ZAP:
                pend.kind = KIND_ERROR;
            M_PAIR:
                pend.ch = fs.quote_kind;
            M_DOT1:
                pend.ch = ".";
            M_DOT2:
                pend.kind = KIND_DOTS2;
            M_NUM, M_NUM_E, M_NUM_S:
                pend.kind = KIND_NUMBER;
            M_NAME:
                pend.kind = word_kind(fs);
            default:
                pend_ok = 1'b0;
        endcase

        if (in_last_reg)
        begin
            if (pend_ok && res_n != 2'd3)
            begin
                slot_next[res_n] = pend; res_n = res_n + 2'd1;
            end
            if (res_n != 2'd3)
            begin
                slot_next[res_n]       = '0;
                slot_next[res_n].kind  = KIND_EOF;
                slot_next[res_n].start = after;
                slot_next[res_n].stop  = after;
                slot_next[res_n].line  = fs.line_count;
                res_n = res_n + 2'd1;
            end
            scan_next = reset_scan();
            pos_next  = '0;
        end
    end

    always_comb
    begin
        cnt_next = cnt_reg;
        idx_next = idx_reg;
        if (process)
        begin
            cnt_next = res_n;
            idx_next = 2'd0;
        end
        else if (drain_done)
        begin
            cnt_next = 2'd0;
            idx_next = 2'd0;
        end
        else if (tok.valid && tok.ready)
            idx_next = idx_reg + 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
            scan_reg   <= reset_scan();
            pos_reg    <= '0;
            cnt_reg    <= 2'd0;
            idx_reg    <= 2'd0;
        end
        else
        begin
            if (src.valid && src.ready)
                in_vld_reg <= 1'b1;
            else if (process)
                in_vld_reg <= 1'b0;
            if (process)
            begin
                scan_reg <= scan_next;
                pos_reg  <= pos_next;
            end
            cnt_reg <= cnt_next;
            idx_reg <= idx_next;
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        if (src.valid && src.ready)
        begin
            in_byte_reg <= src.source_byte;
            in_last_reg <= src.last_byte;
        end
        if (process)
        begin
            for (int i = 0; i < MAX_RESULTS; i++)
                slot_reg[i] <= slot_next[i];
        end
    end

    assign tok.valid       = (cnt_reg != 2'd0);
    assign tok.token_kind  = slot_reg[idx_reg].kind;
    assign tok.token_char  = slot_reg[idx_reg].ch;
    assign tok.token_start = slot_reg[idx_reg].start;
    assign tok.token_end   = slot_reg[idx_reg].stop;
    assign tok.token_line  = slot_reg[idx_reg].line;
    assign tok.last_token  = (idx_reg == cnt_reg - 2'd1);

    // ------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------
    // The read index always stays inside the loaded tokens.
    a_idx_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        tok.valid |-> (idx_reg < cnt_reg))
        else $error("token read index beyond loaded tokens");

    // The end-of-file token is always the final one of its byte.
    a_eof_last: assert property (@(posedge clk) disable iff (!rst_n)
        (tok.valid && tok.token_kind == KIND_EOF) |-> tok.last_token)
        else $error("eof token not last of its byte");

    // A byte that closes the text always restarts the offset.
    a_restart: assert property (@(posedge clk) disable iff (!rst_n)
        (process && in_last_reg) |=> (pos_reg == '0 && scan_reg.mode == M_IDLE))
        else $error("scanner did not restart after end of text");

    // A scanned end-of-text byte always leaves a token to hand out.
    a_eof_loaded: assert property (@(posedge clk) disable iff (!rst_n)
        (process && in_last_reg) |=> (cnt_reg != 2'd0))
        else $error("end of text produced no tokens");

endmodule
